>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the swipe gesture recognizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SWR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define SWR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/swr_pkg.sv
// Types and constants of the swipe gesture recognizer.
`default_nettype none

package swr_pkg;

    localparam int MASS_W  = 27;
    localparam int SUM_W   = 36;
    localparam int THR_W   = 10;
    localparam int DIR_W   = 3;
    localparam int COUNT_W = 2;
    localparam int PX_W    = 10;
    localparam int PY_W    = 9;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;

    localparam logic [MASS_W-1:0] MIN_MASS_RST = MASS_W'(10000);
    localparam logic [THR_W-1:0]  MOVE_THR_RST = THR_W'(20);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Quotient bits needed below the larger frame edge; anything larger saturates.
    localparam int QUOT_W = $clog2((FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT);
    localparam int DIV_SW = MASS_W + QUOT_W;
    localparam int DIV_CW = ((SUM_W > DIV_SW) ? SUM_W : DIV_SW) + 1;
    localparam int STEP_W = $clog2(QUOT_W + 1);

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_DOWN  = 3'd3,
        DIR_UP    = 3'd4
    } t_dir;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV_X,
        S_DIV_Y,
        S_CLASSIFY,
        S_FINISH
    } t_state;

    typedef enum logic {
        REG_MIN_MASS = 1'b0,
        REG_MOVE_THR = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

`default_nettype wire

>>> rtl/swr_if.sv
// Request channels of the swipe gesture recognizer: frame moments in, gestures out.
`default_nettype none

interface swr_in_if import swr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASS_W-1:0] mass;
    logic [SUM_W-1:0]  sum_x;
    logic [SUM_W-1:0]  sum_y;

    modport source (output valid, output mass, output sum_x, output sum_y, input ready);
    modport sink   (input valid, input mass, input sum_x, input sum_y, output ready);
endinterface

interface swr_out_if import swr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIR_W-1:0]   dir_first;
    logic [DIR_W-1:0]   dir_second;
    logic [DIR_W-1:0]   dir_third;
    logic [COUNT_W-1:0] dir_count;

    modport source (output valid, output dir_first, output dir_second, output dir_third,
                    output dir_count, input ready);
    modport sink   (input valid, input dir_first, input dir_second, input dir_third,
                    input dir_count, output ready);
endinterface

`default_nettype wire

>>> rtl/swr_div.sv
// Restoring divider that forms one saturation-aware centroid quotient a bit per cycle.
`default_nettype none
`include "assert_macros.svh"

module swr_div import swr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [MASS_W-1:0] i_divisor,
    output t_div_res          o_res
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_rem, n_rem;
    logic [DIV_SW-1:0] r_dsh, n_dsh;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic              r_ovf, n_ovf;
    logic [DIV_CW-1:0] w_diff;
    logic [DIV_SW-1:0] w_top;

    always_comb begin
        w_top  = {i_divisor, {QUOT_W{1'b0}}};
        w_diff = DIV_CW'(r_rem) - DIV_CW'(r_dsh);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_ovf  = r_ovf;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(QUOT_W);
            n_rem  = i_dividend;
            n_dsh  = w_top >> 1;
            n_quot = '0;
            n_ovf  = DIV_CW'(w_top) <= DIV_CW'(i_dividend);
        end else if (r_busy) begin
            if (!w_diff[DIV_CW-1]) begin
                n_rem = SUM_W'(w_diff);
            end
            n_quot = {r_quot[QUOT_W-2:0], ~w_diff[DIV_CW-1]};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
        r_ovf  <= n_ovf;
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_quot;

    `SWR_ASSERT(a_no_start_busy, i_clk, i_rst_n, (i_start |-> !r_busy), "divider restarted while busy")
    `SWR_ASSERT(a_done_ends_busy, i_clk, i_rst_n, (r_done |-> !r_busy), "divider busy after done")
    `SWR_ASSERT(a_busy_from_start, i_clk, i_rst_n, ($rose(r_busy) |-> $past(i_start)), "divider busy without start")

endmodule

`default_nettype wire

>>> rtl/swipe_gesture_recognizer_top.sv
// Swipe gesture recognizer: marker centroid tracking and direction sequence capture.
//
// Each request carries one frame's marker moments. A frame whose mass exceeds min_mass has
// its centroid formed by one shared restoring divider, x first and then y, one quotient bit
// per cycle. A new frame is accepted only once the previous one has been fully processed
// and the block is back in idle, which includes any wait for the previous gesture to leave
// the output register. A finished gesture waits in that register while the next frame is
// processed.
`default_nettype none
`include "assert_macros.svh"

module swipe_gesture_recognizer_top import swr_pkg::*; #(
    parameter int MAX_DIRS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    swr_in_if.sink            i_in,
    swr_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_DIRS + 1);
    localparam int IDX_W = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
    localparam int DS_W  = PX_W + 2;

    function automatic logic [QUOT_W-1:0] sat_coord(input t_div_res res,
                                                    input logic [QUOT_W-1:0] lim);
        return (res.ovf || (res.quot > lim)) ? lim : res.quot;
    endfunction

    logic [MASS_W-1:0] r_min_mass;
    logic [THR_W-1:0]  r_move_thr;

    t_state            r_state, n_state;
    logic [MASS_W-1:0] r_mass, n_mass;
    logic [SUM_W-1:0]  r_sum_x, n_sum_x;
    logic [SUM_W-1:0]  r_sum_y, n_sum_y;
    logic [PX_W-1:0]   r_cx, n_cx;
    logic [PY_W-1:0]   r_cy, n_cy;
    logic              r_have_prev, n_have_prev;
    logic [PX_W-1:0]   r_prev_x, n_prev_x;
    logic [PY_W-1:0]   r_prev_y, n_prev_y;
    logic              r_moved, n_moved;
    t_dir              r_cur_dir, n_cur_dir;
    t_dir              r_last, n_last;
    t_dir              r_store [MAX_DIRS];
    t_dir              n_store [MAX_DIRS];
    logic [CNT_W-1:0]  r_count, n_count;

    logic               r_out_valid, n_out_valid;
    t_dir               r_out_first, n_out_first;
    t_dir               r_out_second, n_out_second;
    t_dir               r_out_third, n_out_third;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    logic              w_seen;
    logic              w_emit;
    logic              w_out_load;
    logic              w_div_start;
    logic [SUM_W-1:0]  w_div_dividend;
    t_div_res          w_div_res;
    logic signed [DS_W-1:0] w_dx, w_dy, w_t;
    logic              w_dx_small, w_dy_small;
    t_dir              w_pad [3];
    logic              w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mass <= MIN_MASS_RST;
            r_move_thr <= MOVE_THR_RST;
        end else if (w_cfg_write) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_MIN_MASS: r_min_mass <= pwdata[MASS_W-1:0];
                REG_MOVE_THR: r_move_thr <= pwdata[THR_W-1:0];
                default:      r_min_mass <= r_min_mass;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_MIN_MASS: prdata = APB_DW'(r_min_mass);
            REG_MOVE_THR: prdata = APB_DW'(r_move_thr);
            default:      prdata = '0;
        endcase
    end

    for (genvar g = 0; g < 3; g++) begin : g_pad
        if (g < MAX_DIRS) begin : g_used
            assign w_pad[g] = r_store[g];
        end else begin : g_absent
            assign w_pad[g] = DIR_NONE;
        end
    end

    assign w_seen         = r_mass > r_min_mass;
    assign w_div_start    = ((r_state == S_START) && w_seen)
                            || ((r_state == S_DIV_X) && w_div_res.done);
    assign w_div_dividend = (r_state == S_DIV_X) ? r_sum_y : r_sum_x;

    swr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_mass),
        .o_res      (w_div_res)
    );

    always_comb begin
        w_dx       = $signed({2'b00, r_cx}) - $signed({2'b00, r_prev_x});
        w_dy       = $signed({3'b000, r_cy}) - $signed({3'b000, r_prev_y});
        w_t        = $signed({2'b00, r_move_thr});
        w_dx_small = (w_dx < w_t) && (w_dx > -w_t);
        w_dy_small = (w_dy < w_t) && (w_dy > -w_t);
        w_emit     = ((r_mass == '0) && r_moved) || (r_count >= CNT_W'(MAX_DIRS));
        w_out_load = (r_state == S_FINISH) && w_emit && (!r_out_valid || o_out.ready);

        n_state      = r_state;
        n_mass       = r_mass;
        n_sum_x      = r_sum_x;
        n_sum_y      = r_sum_y;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_have_prev  = r_have_prev;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_moved      = r_moved;
        n_cur_dir    = r_cur_dir;
        n_last       = r_last;
        n_store      = r_store;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_third  = r_out_third;
        n_out_count  = r_out_count;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mass  = i_in.mass;
                    n_sum_x = i_in.sum_x;
                    n_sum_y = i_in.sum_y;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = w_seen ? S_DIV_X : S_FINISH;
            end
            S_DIV_X: begin
                if (w_div_res.done) begin
                    n_cx    = PX_W'(sat_coord(w_div_res, QUOT_W'(FRAME_WIDTH - 1)));
                    n_state = S_DIV_Y;
                end
            end
            S_DIV_Y: begin
                if (w_div_res.done) begin
                    n_cy    = PY_W'(sat_coord(w_div_res, QUOT_W'(FRAME_HEIGHT - 1)));
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                n_moved = 1'b1;
                if (r_have_prev) begin
                    priority if ((w_dy < -w_t) && w_dx_small) begin
                        n_cur_dir = DIR_UP;
                    end else if ((w_dy > w_t) && w_dx_small) begin
                        n_cur_dir = DIR_DOWN;
                    end else if ((w_dx < -w_t) && w_dy_small) begin
                        n_cur_dir = DIR_RIGHT;
                    end else if ((w_dx > w_t) && w_dy_small) begin
                        n_cur_dir = DIR_LEFT;
                    end else begin
                        n_cur_dir = r_cur_dir;
                    end
                end
                n_have_prev = 1'b1;
                n_prev_x    = r_cx;
                n_prev_y    = r_cy;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (w_emit) begin
                    if (w_out_load) begin
                        n_out_valid  = 1'b1;
                        n_out_first  = w_pad[0];
                        n_out_second = w_pad[1];
                        n_out_third  = w_pad[2];
                        n_out_count  = (r_count > CNT_W'(3)) ? COUNT_W'(3) : COUNT_W'(r_count);
                        n_have_prev  = 1'b0;
                        n_prev_x     = '0;
                        n_prev_y     = '0;
                        n_moved      = 1'b0;
                        n_cur_dir    = DIR_NONE;
                        n_last       = DIR_NONE;
                        n_count      = '0;
                        for (int i = 0; i < MAX_DIRS; i++) begin
                            n_store[i] = DIR_NONE;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    if ((r_last != r_cur_dir) && (r_count < CNT_W'(MAX_DIRS))) begin
                        n_store[r_count[IDX_W-1:0]] = r_cur_dir;
                        n_count = r_count + CNT_W'(1);
                        n_last  = r_cur_dir;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_moved     <= 1'b0;
            r_cur_dir   <= DIR_NONE;
            r_last      <= DIR_NONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_DIRS; i++) begin
                r_store[i] <= DIR_NONE;
            end
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_moved     <= n_moved;
            r_cur_dir   <= n_cur_dir;
            r_last      <= n_last;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_store     <= n_store;
        end
        r_mass       <= n_mass;
        r_sum_x      <= n_sum_x;
        r_sum_y      <= n_sum_y;
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_third  <= n_out_third;
        r_out_count  <= n_out_count;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.dir_first  = r_out_first;
    assign o_out.dir_second = r_out_second;
    assign o_out.dir_third  = r_out_third;
    assign o_out.dir_count  = r_out_count;

    `SWR_ASSERT(a_div_done_in_div, i_clk, i_rst_n, (w_div_res.done |-> (r_state == S_DIV_X || r_state == S_DIV_Y)), "divider result outside a divide state")
    `SWR_ASSERT(a_emit_clears, i_clk, i_rst_n, (w_out_load |=> (r_count == '0 && !r_moved && !r_have_prev)), "gesture not cleared after emission")
    `SWR_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= CNT_W'(MAX_DIRS)), "direction count beyond store depth")
    `SWR_ASSERT_ALWAYS(a_last_empty, i_clk, ((r_count == '0) |-> (r_last == DIR_NONE)), "last direction set with empty store")

endmodule

`default_nettype wire
